// ===== hw/rtl/round_robin_task_scheduler_defines.svh =====
// Assertion macros for the round-robin task scheduler.
// Each use expects clk_i and rst_ni in scope; no other dependencies.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define RRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// No dependencies; used by the top level and by anything driving its channels.
package rrts_pkg;

  localparam int unsigned DEFAULT_TASK_SLOTS = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned LIVE_W  = 5;
  localparam int unsigned COUNT_W = 32;

  localparam logic [SLICE_W-1:0] IDLE_SLICE_RESET = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CHECK   = 3'd1,
    CMD_YIELD   = 3'd2,
    CMD_BLOCK   = 3'd3,
    CMD_UNBLOCK = 3'd4,
    CMD_EXIT    = 3'd5,
    CMD_CREATE  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } task_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [SLICE_W-1:0] slice;
  } cmd_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  current_slot;
    logic               switched;
    logic               resched_pending;
    logic               status;
    logic [LIVE_W-1:0]  live_tasks;
    logic [COUNT_W-1:0] switch_count;
  } res_beat_t;

  typedef logic [SLICE_W-1:0] cfg_beat_t;

endpackage

// ===== hw/rtl/rrts_stream_if.sv =====
// Valid/ready channel carrying one beat of a configurable payload type.
// No dependencies; payload types come from rrts_pkg at instantiation.
interface rrts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler: a command beat passes the command register, then the
// result register; throughput one command per cycle unless res_o.ready stalls it.
// The rate is set by the slot update and find-first search, done combinationally.
// Reset (async, active low): slot 0 running with a slice of 10, all other slots
// free, switch count zeroed, live total 1. No clearing pass; ready to accept after reset.
`include "round_robin_task_scheduler_defines.svh"

module round_robin_task_scheduler #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::DEFAULT_TASK_SLOTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  rrts_stream_if.sink   cmd_i,
  rrts_stream_if.source res_o,
  rrts_stream_if.sink   cfg_i
);
  import rrts_pkg::*;

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam int unsigned TOT_W = $clog2(TASK_SLOTS + 1);

  typedef logic [IDX_W-1:0] idx_t;

  // command register
  logic      in_vld_q;
  cmd_beat_t in_q;
  logic      adv;

  // slot table and scheduler state
  task_state_e        status_q [TASK_SLOTS];
  task_state_e        status_d [TASK_SLOTS];
  logic [SLICE_W-1:0] slice_q  [TASK_SLOTS];
  logic [SLICE_W-1:0] slice_d  [TASK_SLOTS];
  logic [SLICE_W-1:0] ticks_q  [TASK_SLOTS];
  logic [SLICE_W-1:0] ticks_d  [TASK_SLOTS];
  idx_t               run_q, run_d;
  logic               resched_q, resched_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [COUNT_W-1:0] swcnt_q, swcnt_d;

  // result register
  logic      res_vld_q;
  res_beat_t res_q, res_d;

  // next-task search
  logic [TASK_SLOTS-1:0] rdy_vec;
  logic [TASK_SLOTS-1:0] live_vec;
  logic                  hi_any, lo_any;
  idx_t                  hi_idx, lo_idx, nxt_idx;

  logic               slot_ok;
  idx_t               slot_idx;
  logic [SLICE_W-1:0] ticks_run;
  logic               do_yield, do_go, do_reload, ign;
  idx_t               target;

  assign adv          = in_vld_q && (!res_vld_q || res_o.ready);
  assign cmd_i.ready  = !in_vld_q || adv;
  assign cfg_i.ready  = 1'b1;
  assign res_o.valid  = res_vld_q;
  assign res_o.data   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q <= cmd_i.data;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(TASK_SLOTS); i++) begin
      rdy_vec[i]  = (status_q[i] == ST_READY) && (idx_t'(i) != run_q);
      live_vec[i] = (status_q[i] != ST_FREE);
    end
  end

  // first ready slot above the running one, else the lowest ready slot
  always_comb begin
    hi_any = 1'b0;
    hi_idx = '0;
    lo_any = 1'b0;
    lo_idx = '0;
    for (int i = int'(TASK_SLOTS) - 1; i >= 0; i--) begin
      if (rdy_vec[i]) begin
        lo_any = 1'b1;
        lo_idx = idx_t'(i);
        if (idx_t'(i) > run_q) begin
          hi_any = 1'b1;
          hi_idx = idx_t'(i);
        end
      end
    end
  end

  assign nxt_idx   = hi_any ? hi_idx : lo_idx;
  assign slot_ok   = (32'(in_q.slot) < 32'(TASK_SLOTS));
  assign slot_idx  = idx_t'(in_q.slot);
  assign ticks_run = ticks_q[run_q];

  always_comb begin
    status_d  = status_q;
    slice_d   = slice_q;
    ticks_d   = ticks_q;
    run_d     = run_q;
    resched_d = resched_q;
    total_d   = total_q;
    swcnt_d   = swcnt_q;
    do_yield  = 1'b0;
    do_go     = 1'b0;
    do_reload = 1'b0;
    ign       = 1'b0;

    unique case (in_q.cmd)
      CMD_TICK: begin
        if (ticks_run != '0) begin
          ticks_d[run_q] = ticks_run - SLICE_W'(1);
        end
        if (ticks_run <= SLICE_W'(1)) begin
          resched_d = 1'b1;
        end
      end
      CMD_CHECK: begin
        if (resched_q) begin
          resched_d = 1'b0;
          do_yield  = 1'b1;
        end else begin
          ign = 1'b1;
        end
      end
      CMD_YIELD: begin
        do_yield = 1'b1;
      end
      CMD_BLOCK: begin
        if (run_q == '0) begin
          ign = 1'b1;
        end else begin
          status_d[run_q] = ST_BLOCKED;
          do_go           = 1'b1;
          do_reload       = 1'b1;
        end
      end
      CMD_UNBLOCK: begin
        if (slot_ok && status_q[slot_idx] == ST_BLOCKED) begin
          status_d[slot_idx] = ST_READY;
        end else begin
          ign = 1'b1;
        end
      end
      CMD_EXIT: begin
        if (run_q == '0) begin
          ign = 1'b1;
        end else begin
          status_d[run_q] = ST_FREE;
          slice_d[run_q]  = '0;
          ticks_d[run_q]  = '0;
          total_d         = total_q - TOT_W'(1);
          do_go           = 1'b1;
        end
      end
      CMD_CREATE: begin
        if (slot_ok && status_q[slot_idx] == ST_FREE) begin
          status_d[slot_idx] = ST_READY;
          slice_d[slot_idx]  = in_q.slice;
          ticks_d[slot_idx]  = in_q.slice;
          total_d            = total_q + TOT_W'(1);
        end else begin
          ign = 1'b1;
        end
      end
      default: begin
        ign = 1'b1;
      end
    endcase

    // yield with no other ready slot keeps the running task
    if (do_yield && lo_any) begin
      status_d[run_q] = ST_READY;
      do_go           = 1'b1;
      do_reload       = 1'b1;
    end

    target = lo_any ? nxt_idx : '0;
    if (do_go) begin
      status_d[target] = ST_RUNNING;
      run_d            = target;
      swcnt_d          = swcnt_q + COUNT_W'(1);
      if (do_reload) begin
        ticks_d[target] = slice_q[target];
      end
    end

    res_d.current_slot    = SLOT_W'(run_d);
    res_d.switched        = (run_d != run_q);
    res_d.resched_pending = resched_d;
    res_d.status          = ign;
    res_d.live_tasks      = LIVE_W'(total_d);
    res_d.switch_count    = swcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(TASK_SLOTS); i++) begin
        status_q[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
        slice_q[i]  <= (i == 0) ? IDLE_SLICE_RESET : '0;
        ticks_q[i]  <= (i == 0) ? IDLE_SLICE_RESET : '0;
      end
      run_q     <= '0;
      resched_q <= 1'b0;
      total_q   <= TOT_W'(1);
      swcnt_q   <= '0;
    end else begin
      if (adv) begin
        status_q  <= status_d;
        ticks_q   <= ticks_d;
        for (int i = 1; i < int'(TASK_SLOTS); i++) begin
          slice_q[i] <= slice_d[i];
        end
        run_q     <= run_d;
        resched_q <= resched_d;
        total_q   <= total_d;
        swcnt_q   <= swcnt_d;
      end
      // idle slice write replaces slot 0's reload value only
      if (cfg_i.valid) begin
        slice_q[0] <= cfg_i.data;
      end else if (adv) begin
        slice_q[0] <= slice_d[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  `RRTS_ASSERT(a_run_slot_running, status_q[run_q] == ST_RUNNING, "running slot not marked running")
  `RRTS_ASSERT(a_idle_slot_live, status_q[0] != ST_FREE, "idle slot freed")
  `RRTS_ASSERT(a_total_matches, 32'(total_q) == $countones(live_vec), "task total out of step")
  `RRTS_ASSERT_NEXT(a_switch_counted, adv && res_d.switched, res_q.switch_count == $past(swcnt_q) + 32'd1, "switch not counted")

endmodule
